>>> sv/rbe_pkg.sv
`default_nettype none
package rbe_pkg;

   localparam int COORD_W    = 32;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int PROD_W     = DIFF_W + COORD_W;
   localparam int NMAG_W     = PROD_W - 2;
   localparam int DMAG_W     = COORD_W;
   localparam int QUO_W      = 52;
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = QUO_W / DIV_STEPS;
   localparam int CUT_LAT    = DIV_STAGES + 4;
   localparam int SEL_LAT    = 2;
   localparam int RSP_LAT    = CUT_LAT + SEL_LAT;
   localparam int VAL_W      = 52;
   localparam int NUM_CUTS   = 12;
   localparam int NUM_FACES  = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int Q_LIMIT_EXP = 50;
   localparam logic [QUO_W-1:0] Q_LIMIT = QUO_W'(1) << Q_LIMIT_EXP;

   localparam logic signed [COORD_W-1:0] RST_X_LOW  = -32'sd5120000;
   localparam logic signed [COORD_W-1:0] RST_X_HIGH = 32'sd5120000;
   localparam logic signed [COORD_W-1:0] RST_Y_LOW  = -32'sd15488000;
   localparam logic signed [COORD_W-1:0] RST_Y_HIGH = 32'sd15488000;
   localparam logic signed [COORD_W-1:0] RST_Z_LOW  = -32'sd5120000;
   localparam logic signed [COORD_W-1:0] RST_Z_HIGH = 32'sd5120000;
   localparam logic signed [COORD_W-1:0] MIN_STEP   = 32'sd1;

   typedef enum logic [2:0] {
      FACE_NONE, FACE_Z_TOP, FACE_Z_BOTTOM, FACE_X_HIGH,
      FACE_X_LOW, FACE_Y_HIGH, FACE_Y_LOW
   } face_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_LOW, CSR_X_HIGH, CSR_Y_LOW, CSR_Y_HIGH, CSR_Z_LOW, CSR_Z_HIGH
   } csr_idx_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic signed [COORD_W-1:0] dir_x;
      logic signed [COORD_W-1:0] dir_y;
      logic signed [COORD_W-1:0] dir_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] entry_x;
      logic signed [COORD_W-1:0] entry_y;
      logic signed [COORD_W-1:0] entry_z;
      logic [2:0]                entry_face;
      logic [2:0]                hit_count;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x_low;
      logic signed [COORD_W-1:0] x_high;
      logic signed [COORD_W-1:0] y_low;
      logic signed [COORD_W-1:0] y_high;
      logic signed [COORD_W-1:0] z_low;
      logic signed [COORD_W-1:0] z_high;
   } box_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0]  diff;
      logic signed [COORD_W-1:0] c_other;
      logic signed [COORD_W-1:0] c_axis;
      logic signed [COORD_W-1:0] p_other;
   } cut_op_type;

endpackage
`default_nettype wire

>>> sv/rbe_cut.sv
`default_nettype none
// one face cut: p_other + clamp((diff * c_other) / c_axis), truncating division
module rbe_cut
   import rbe_pkg::*;
(
   input  logic                     clock,
   input  cut_op_type               op,
   output logic signed [VAL_W-1:0]  result
);

   cut_op_type op_ff;

   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [COORD_W-1:0] c_axis2_ff;
   logic signed [COORD_W-1:0] p_other2_ff;

   logic [NMAG_W-1:0] nmag;
   logic [DMAG_W-1:0] dmag;
   logic [PROD_W-1:0] prod_neg;
   logic [COORD_W:0]  c_neg;

   // divider pipeline, entry 0 loaded from the magnitude stage
   logic [DMAG_W-1:0]         rem_ff   [DIV_STAGES+1];
   logic [QUO_W-1:0]          nlo_ff   [DIV_STAGES+1];
   logic [QUO_W-1:0]          quo_ff   [DIV_STAGES+1];
   logic [DMAG_W-1:0]         dmag_ff  [DIV_STAGES+1];
   logic                      neg_ff   [DIV_STAGES+1];
   logic                      ovf_ff   [DIV_STAGES+1];
   logic signed [COORD_W-1:0] pot_ff   [DIV_STAGES+1];

   logic [QUO_W-1:0]         q_clamped;
   logic [QUO_W:0]           q_signed;
   logic signed [QUO_W:0]    sum;
   logic signed [VAL_W-1:0]  result_ff;

   always_ff @(posedge clock) begin
      op_ff       <= op;
      prod_ff     <= op_ff.diff * op_ff.c_other;
      c_axis2_ff  <= op_ff.c_axis;
      p_other2_ff <= op_ff.p_other;
   end

   always_comb begin
      prod_neg = -prod_ff;
      c_neg    = -{c_axis2_ff[COORD_W-1], c_axis2_ff};
      nmag     = prod_ff[PROD_W-1] ? prod_neg[NMAG_W-1:0] : prod_ff[NMAG_W-1:0];
      dmag     = c_axis2_ff[COORD_W-1] ? c_neg[DMAG_W-1:0] : c_axis2_ff;
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= DMAG_W'(nmag[NMAG_W-1:QUO_W]);
      nlo_ff[0]  <= nmag[QUO_W-1:0];
      quo_ff[0]  <= '0;
      dmag_ff[0] <= dmag;
      neg_ff[0]  <= prod_ff[PROD_W-1] ^ c_axis2_ff[COORD_W-1];
      ovf_ff[0]  <= DMAG_W'(nmag[NMAG_W-1:QUO_W]) >= dmag;
      pot_ff[0]  <= p_other2_ff;
   end

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      logic [DMAG_W:0]       trial [DIV_STEPS];
      logic [DMAG_W-1:0]     rem   [DIV_STEPS+1];
      logic [DIV_STEPS-1:0]  qbits;

      always_comb begin
         rem[0] = rem_ff[s];
         for (int k = 0; k < DIV_STEPS; k++) begin
            trial[k] = {rem[k], nlo_ff[s][QUO_W-1-k]};
            if (trial[k] >= {1'b0, dmag_ff[s]}) begin
               rem[k+1]               = DMAG_W'(trial[k] - {1'b0, dmag_ff[s]});
               qbits[DIV_STEPS-1-k]   = 1'b1;
            end else begin
               rem[k+1]               = trial[k][DMAG_W-1:0];
               qbits[DIV_STEPS-1-k]   = 1'b0;
            end
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s+1]  <= rem[DIV_STEPS];
         nlo_ff[s+1]  <= nlo_ff[s] << DIV_STEPS;
         quo_ff[s+1]  <= {quo_ff[s][QUO_W-DIV_STEPS-1:0], qbits};
         dmag_ff[s+1] <= dmag_ff[s];
         neg_ff[s+1]  <= neg_ff[s];
         ovf_ff[s+1]  <= ovf_ff[s];
         pot_ff[s+1]  <= pot_ff[s];
      end
   end

   always_comb begin
      q_clamped = (ovf_ff[DIV_STAGES] || quo_ff[DIV_STAGES] > Q_LIMIT)
                  ? Q_LIMIT : quo_ff[DIV_STAGES];
      q_signed  = neg_ff[DIV_STAGES] ? -{1'b0, q_clamped} : {1'b0, q_clamped};
      sum       = $signed(q_signed) + (QUO_W+1)'(pot_ff[DIV_STAGES]);
   end

   always_ff @(posedge clock) begin
      result_ff <= sum[VAL_W-1:0];
   end

   assign result = result_ff;

endmodule
`default_nettype wire

>>> sv/rbe_select.sv
`default_nettype none
// face hit tests, then first/latest pick
module rbe_select
   import rbe_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic signed [VAL_W-1:0] cut_res [NUM_CUTS],
   input  box_type                 box,
   output logic                    rsp_valid,
   output rsp_type                 rsp_data
);

   logic signed [VAL_W-1:0] xl, xh, yl, yh, zl, zh;
   logic signed [VAL_W-1:0] vx [NUM_FACES];
   logic signed [VAL_W-1:0] vy [NUM_FACES];
   logic signed [VAL_W-1:0] vz [NUM_FACES];
   logic [NUM_FACES-1:0]    hit;

   logic                    valid_a_ff;
   logic signed [VAL_W-1:0] vx_ff [NUM_FACES];
   logic signed [VAL_W-1:0] vy_ff [NUM_FACES];
   logic signed [VAL_W-1:0] vz_ff [NUM_FACES];
   logic [NUM_FACES-1:0]    hit_ff;

   logic [2:0]  first_idx, last_idx, pick_idx;
   logic [2:0]  count;
   rsp_type     rsp_in;
   rsp_type     rsp_ff;
   logic        valid_b_ff;

   function automatic logic signed [COORD_W-1:0] sat(logic signed [VAL_W-1:0] v);
      logic signed [VAL_W-1:0] hi;
      logic signed [VAL_W-1:0] lo;
      hi = VAL_W'({1'b0, {(COORD_W-1){1'b1}}});
      lo = -hi - 1;
      if (v > hi) return hi[COORD_W-1:0];
      if (v < lo) return lo[COORD_W-1:0];
      return v[COORD_W-1:0];
   endfunction

   always_comb begin
      xl = VAL_W'(box.x_low);
      xh = VAL_W'(box.x_high);
      yl = VAL_W'(box.y_low);
      yh = VAL_W'(box.y_high);
      zl = VAL_W'(box.z_low);
      zh = VAL_W'(box.z_high);
      // z top, z bottom
      vx[0] = cut_res[0];  vy[0] = cut_res[1];  vz[0] = zh;
      vx[1] = cut_res[2];  vy[1] = cut_res[3];  vz[1] = zl;
      // x high, x low
      vx[2] = xh;          vy[2] = cut_res[4];  vz[2] = cut_res[5];
      vx[3] = xl;          vy[3] = cut_res[6];  vz[3] = cut_res[7];
      // y high, y low
      vx[4] = cut_res[8];  vy[4] = yh;          vz[4] = cut_res[9];
      vx[5] = cut_res[10]; vy[5] = yl;          vz[5] = cut_res[11];
      for (int f = 0; f < 2; f++)
         hit[f] = vx[f] > xl && vx[f] < xh && vy[f] > yl && vy[f] < yh;
      for (int f = 2; f < 4; f++)
         hit[f] = vz[f] > zl && vz[f] < zh && vy[f] > yl && vy[f] < yh;
      for (int f = 4; f < 6; f++)
         hit[f] = vz[f] > zl && vz[f] < zh && vx[f] > xl && vx[f] < xh;
   end

   always_ff @(posedge clock) begin
      vx_ff  <= vx;
      vy_ff  <= vy;
      vz_ff  <= vz;
      hit_ff <= hit;
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
      end
   end

   always_comb begin
      first_idx = 3'd1;
      last_idx  = 3'd1;
      for (int f = NUM_FACES - 1; f >= 1; f--)
         if (hit_ff[f]) first_idx = 3'(f);
      for (int f = 1; f < NUM_FACES; f++)
         if (hit_ff[f]) last_idx = 3'(f);
      count = 3'($countones(hit_ff[NUM_FACES-1:1]));
      if (count == 3'd1 || vz_ff[first_idx] > vz_ff[last_idx])
         pick_idx = first_idx;
      else
         pick_idx = last_idx;

      if (hit_ff[0]) begin
         rsp_in.entry_x    = sat(vx_ff[0]);
         rsp_in.entry_y    = sat(vy_ff[0]);
         rsp_in.entry_z    = sat(vz_ff[0]);
         rsp_in.entry_face = FACE_Z_TOP;
         rsp_in.hit_count  = 3'd1;
      end else if (count == 3'd0) begin
         rsp_in.entry_x    = '0;
         rsp_in.entry_y    = '0;
         rsp_in.entry_z    = '0;
         rsp_in.entry_face = FACE_NONE;
         rsp_in.hit_count  = 3'd0;
      end else begin
         rsp_in.entry_x    = sat(vx_ff[pick_idx]);
         rsp_in.entry_y    = sat(vy_ff[pick_idx]);
         rsp_in.entry_z    = sat(vz_ff[pick_idx]);
         rsp_in.entry_face = pick_idx + 3'd1;
         rsp_in.hit_count  = count;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else begin
         valid_b_ff <= valid_a_ff;
      end
   end

   assign rsp_valid = valid_b_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

>>> sv/ray_box_entry_point.sv
// Ray entry point into an axis-aligned box.
// Input: pulse start with a ray in req_data (point Q24.8 mm, direction Q1.30);
// the item is taken at a clock edge with start high and busy low. busy never
// rises, so a new item may be given every cycle.
// Output: rsp_valid strobes for one cycle with the answer in rsp_data; the
// receiver must take it then, nothing is held back.
// Throughput: one item per cycle. Twelve face cuts run side by side, each a
// multiplier stage and a 13-stage restoring divider (4 quotient bits per
// stage), followed by a hit-test stage and a pick stage.
// Box bounds: csr_we writes csr_wdata to register csr_index (0..5: x low,
// x high, y low, y high, z low, z high); other indexes are ignored. Bounds
// are read live by the pipeline, so write them only with no item in flight.
// Reset (synchronous) clears all items in flight and restores the default box.
`default_nettype none
module ray_box_entry_point
   import rbe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_wdata
);

   box_type box_ff;

   logic signed [COORD_W-1:0] cxr, cyr, czr;
   cut_op_type                cut_op  [NUM_CUTS];
   logic signed [VAL_W-1:0]   cut_res [NUM_CUTS];
   logic [CUT_LAT-1:0]        valid_ff;
   logic [CUT_LAT-1:0]        valid_in;
   logic                      accept;

   // never stalls
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // box registers
   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff.x_low  <= RST_X_LOW;
         box_ff.x_high <= RST_X_HIGH;
         box_ff.y_low  <= RST_Y_LOW;
         box_ff.y_high <= RST_Y_HIGH;
         box_ff.z_low  <= RST_Z_LOW;
         box_ff.z_high <= RST_Z_HIGH;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_X_LOW:  box_ff.x_low  <= csr_wdata;
            CSR_X_HIGH: box_ff.x_high <= csr_wdata;
            CSR_Y_LOW:  box_ff.y_low  <= csr_wdata;
            CSR_Y_HIGH: box_ff.y_high <= csr_wdata;
            CSR_Z_LOW:  box_ff.z_low  <= csr_wdata;
            CSR_Z_HIGH: box_ff.z_high <= csr_wdata;
            default: ;
         endcase
      end
   end

   // zero direction components become one LSB; divisors always use these,
   // numerators only once that axis has been reached in the face order
   always_comb begin
      cxr = (req_data.dir_x == '0) ? MIN_STEP : req_data.dir_x;
      cyr = (req_data.dir_y == '0) ? MIN_STEP : req_data.dir_y;
      czr = (req_data.dir_z == '0) ? MIN_STEP : req_data.dir_z;
   end

   function automatic cut_op_type mk_op(logic signed [COORD_W-1:0] p_other,
                                        logic signed [COORD_W-1:0] bound,
                                        logic signed [COORD_W-1:0] p_axis,
                                        logic signed [COORD_W-1:0] c_other,
                                        logic signed [COORD_W-1:0] c_axis);
      cut_op_type o;
      o.diff    = DIFF_W'(bound) - DIFF_W'(p_axis);
      o.c_other = c_other;
      o.c_axis  = c_axis;
      o.p_other = p_other;
      return o;
   endfunction

   always_comb begin
      // z top
      cut_op[0]  = mk_op(req_data.point_x, box_ff.z_high, req_data.point_z,
                         req_data.dir_x, czr);
      cut_op[1]  = mk_op(req_data.point_y, box_ff.z_high, req_data.point_z,
                         req_data.dir_y, czr);
      // z bottom
      cut_op[2]  = mk_op(req_data.point_x, box_ff.z_low, req_data.point_z,
                         req_data.dir_x, czr);
      cut_op[3]  = mk_op(req_data.point_y, box_ff.z_low, req_data.point_z,
                         req_data.dir_y, czr);
      // x high, x low: dir_y still raw
      cut_op[4]  = mk_op(req_data.point_y, box_ff.x_high, req_data.point_x,
                         req_data.dir_y, cxr);
      cut_op[5]  = mk_op(req_data.point_z, box_ff.x_high, req_data.point_x, czr, cxr);
      cut_op[6]  = mk_op(req_data.point_y, box_ff.x_low, req_data.point_x,
                         req_data.dir_y, cxr);
      cut_op[7]  = mk_op(req_data.point_z, box_ff.x_low, req_data.point_x, czr, cxr);
      // y high, y low
      cut_op[8]  = mk_op(req_data.point_x, box_ff.y_high, req_data.point_y, cxr, cyr);
      cut_op[9]  = mk_op(req_data.point_z, box_ff.y_high, req_data.point_y, czr, cyr);
      cut_op[10] = mk_op(req_data.point_x, box_ff.y_low, req_data.point_y, cxr, cyr);
      cut_op[11] = mk_op(req_data.point_z, box_ff.y_low, req_data.point_y, czr, cyr);
   end

   for (genvar i = 0; i < NUM_CUTS; i++) begin : g_cut
      rbe_cut u_cut (
         .clock  (clock),
         .op     (cut_op[i]),
         .result (cut_res[i])
      );
   end

   // item valid travels alongside the cut pipeline
   assign valid_in = {valid_ff[CUT_LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   rbe_select u_select (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_ff[CUT_LAT-1]),
      .cut_res   (cut_res),
      .box       (box_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // every answer comes from an item taken a fixed time before
   a_rsp_from_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, RSP_LAT))
      else $error("answer without an item");

   // no hit gives a cleared answer
   a_none_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.entry_face == FACE_NONE |->
         rsp_data.hit_count == 3'd0 && rsp_data.entry_x == '0 &&
         rsp_data.entry_y == '0 && rsp_data.entry_z == '0)
      else $error("no-hit answer not cleared");

   // a top hit stands alone
   a_top_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.entry_face == FACE_Z_TOP |->
         rsp_data.hit_count == 3'd1 && rsp_data.entry_z == box_ff.z_high)
      else $error("top hit count or z wrong");

   // hit count never exceeds the five later faces
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.hit_count <= 3'd5 &&
         ((rsp_data.hit_count == 3'd0) == (rsp_data.entry_face == FACE_NONE)))
      else $error("hit count out of range");

endmodule
`default_nettype wire

>>> tb/sv/ray_box_entry_point_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module ray_box_entry_point_checker
   import rbe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_wdata,
   output int                   fails,
   output int                   pending
);

   localparam longint CLAMP = longint'(1) << 50;

   box_type box;
   rsp_type entry_queue[$];

   function automatic longint cut_at(longint p_o, longint bound, longint p_a,
                                     longint c_o, longint c_a);
      longint q;
      q = ((bound - p_a) * c_o) / c_a;
      if (q > CLAMP) q = CLAMP;
      if (q < -CLAMP) q = -CLAMP;
      return p_o + q;
   endfunction

   function automatic logic signed [COORD_W-1:0] sat_coord(longint v);
      if (v > 64'sd2147483647) return 32'sh7fff_ffff;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[COORD_W-1:0];
   endfunction

   function automatic bit strictly_in(longint v, longint lo, longint hi);
      return v > lo && v < hi;
   endfunction

   function automatic rsp_type predict_entry(req_type r, box_type b);
      rsp_type res;
      longint px, py, pz, cx, cy, cz;
      longint xl, xh, yl, yh, zl, zh, bd;
      longint v[3], first[3], last[3];
      face_type ff, lf;
      int hits;
      bit hit;
      px = r.point_x; py = r.point_y; pz = r.point_z;
      cx = r.dir_x; cy = r.dir_y; cz = r.dir_z;
      xl = b.x_low; xh = b.x_high; yl = b.y_low;
      yh = b.y_high; zl = b.z_low; zh = b.z_high;
      res = '0;
      hits = 0;
      ff = FACE_NONE;
      lf = FACE_NONE;
      first = '{0, 0, 0};
      last = '{0, 0, 0};
      if (cz == 0) cz = 1;
      v[0] = cut_at(px, zh, pz, cx, cz);
      v[1] = cut_at(py, zh, pz, cy, cz);
      if (strictly_in(v[0], xl, xh) && strictly_in(v[1], yl, yh)) begin
         res.entry_x = sat_coord(v[0]);
         res.entry_y = sat_coord(v[1]);
         res.entry_z = sat_coord(zh);
         res.entry_face = FACE_Z_TOP;
         res.hit_count = 3'd1;
         return res;
      end
      for (int f = FACE_Z_BOTTOM; f <= FACE_Y_LOW; f++) begin
         // zero components swapped for a minimal step only from their own faces on
         if (f == FACE_X_HIGH && cx == 0) cx = 1;
         if (f == FACE_Y_HIGH && cy == 0) cy = 1;
         if (f == FACE_Z_BOTTOM) begin
            v[0] = cut_at(px, zl, pz, cx, cz);
            v[1] = cut_at(py, zl, pz, cy, cz);
            v[2] = zl;
            hit = strictly_in(v[0], xl, xh) && strictly_in(v[1], yl, yh);
         end else if (f <= FACE_X_LOW) begin
            bd = (f == FACE_X_HIGH) ? xh : xl;
            v[0] = bd;
            v[1] = cut_at(py, bd, px, cy, cx);
            v[2] = cut_at(pz, bd, px, cz, cx);
            hit = strictly_in(v[2], zl, zh) && strictly_in(v[1], yl, yh);
         end else begin
            bd = (f == FACE_Y_HIGH) ? yh : yl;
            v[0] = cut_at(px, bd, py, cx, cy);
            v[1] = bd;
            v[2] = cut_at(pz, bd, py, cz, cy);
            hit = strictly_in(v[2], zl, zh) && strictly_in(v[0], xl, xh);
         end
         if (hit) begin
            hits++;
            if (hits == 1) begin
               first = v;
               ff = face_type'(f);
            end else begin
               last = v;
               lf = face_type'(f);
            end
         end
      end
      if (hits == 0) return res;
      if (hits == 1 || first[2] > last[2]) begin
         v = first;
         res.entry_face = ff;
      end else begin
         v = last;
         res.entry_face = lf;
      end
      res.entry_x = sat_coord(v[0]);
      res.entry_y = sat_coord(v[1]);
      res.entry_z = sat_coord(v[2]);
      res.hit_count = hits[2:0];
      return res;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("%0t: %s mismatch, got %0d want %0d", $realtime, what, got, want);
      fails++;
   endtask

   initial begin
      fails = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         box <= '{RST_X_LOW, RST_X_HIGH, RST_Y_LOW, RST_Y_HIGH, RST_Z_LOW, RST_Z_HIGH};
         entry_queue.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_X_LOW: begin
                  box.x_low <= csr_wdata;
               end
               CSR_X_HIGH: begin
                  box.x_high <= csr_wdata;
               end
               CSR_Y_LOW: begin
                  box.y_low <= csr_wdata;
               end
               CSR_Y_HIGH: begin
                  box.y_high <= csr_wdata;
               end
               CSR_Z_LOW: begin
                  box.z_low <= csr_wdata;
               end
               CSR_Z_HIGH: begin
                  box.z_high <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (start && !busy) entry_queue.push_back(predict_entry(req_data, box));
         if (rsp_valid) begin
            if (entry_queue.size() == 0) begin
               report("unexpected item", 1, 0);
            end else begin
               want = entry_queue.pop_front();
               if (rsp_data.entry_x !== want.entry_x)
                  report("entry_x", rsp_data.entry_x, want.entry_x);
               if (rsp_data.entry_y !== want.entry_y)
                  report("entry_y", rsp_data.entry_y, want.entry_y);
               if (rsp_data.entry_z !== want.entry_z)
                  report("entry_z", rsp_data.entry_z, want.entry_z);
               if (rsp_data.entry_face !== want.entry_face)
                  report("entry_face", rsp_data.entry_face, want.entry_face);
               if (rsp_data.hit_count !== want.hit_count)
                  report("hit_count", rsp_data.hit_count, want.hit_count);
            end
         end
      end
      pending <= entry_queue.size();
   end

endmodule
`default_nettype wire

>>> tb/sv/ray_box_entry_point_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module ray_box_entry_point_tb;
   import rbe_pkg::*;

   // indexes past the register list; writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam int    STALL_LIMIT = 5000;
   localparam int    PHASE_ITEMS = 370;
   localparam longint UNIT = longint'(1) << 30;   // direction of length one

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_data;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COORD_W-1:0]   csr_wdata;
   int                   fails;
   int                   pending;
   int                   quiet_cycles;
   box_type              cur_box;

   ray_box_entry_point dut (.*);

   ray_box_entry_point_checker checker_i (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .csr_we, .csr_index, .csr_wdata, .fails, .pending
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog: runs out when neither side moves an item for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   function automatic logic signed [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fff_ffff;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // position scattered around a box span, spilling past both faces
   function automatic logic signed [31:0] near_span(longint lo, longint hi);
      longint s, r;
      s = hi - lo;
      if (s < 2) s = 4096;
      r = longint'({$urandom, $urandom} & 64'h3fff_ffff_ffff_ffff);
      return clip32(lo - s / 2 + r % (2 * s));
   endfunction

   // direction component: sometimes zero or a full unit, else anywhere in range
   function automatic logic signed [31:0] rand_dir();
      case ($urandom_range(9))
         0: return 32'sd0;
         1: return $urandom_range(1) ? 32'sh4000_0000 : 32'shc000_0000;
         2: return $signed($urandom_range(7)) - 32'sd3;
         default: return 32'(longint'($urandom_range(32'h8000_0000, 0)) - UNIT);
      endcase
   endfunction

   function automatic req_type rand_ray();
      req_type r;
      if ($urandom_range(9) == 0) begin
         // noise over the whole field range
         r.point_x = $urandom;
         r.point_y = $urandom;
         r.point_z = $urandom;
      end else begin
         r.point_x = near_span(cur_box.x_low, cur_box.x_high);
         r.point_y = near_span(cur_box.y_low, cur_box.y_high);
         r.point_z = near_span(cur_box.z_low, cur_box.z_high);
      end
      r.dir_x = rand_dir();
      r.dir_y = rand_dir();
      r.dir_z = rand_dir();
      return r;
   endfunction

   function automatic int rand_gap();
      case ($urandom_range(19))
         0: return $urandom_range(40, 10);
         1, 2, 3, 4, 5: return $urandom_range(3, 1);
         default: return 0;
      endcase
   endfunction

   task automatic send_ray(req_type r, int gap);
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic ray(longint px, longint py, longint pz, longint cx, longint cy, longint cz);
      send_ray('{clip32(px), clip32(py), clip32(pz), clip32(cx), clip32(cy), clip32(cz)},
               rand_gap());
   endtask

   // waits until nothing is in flight before writing the box
   task automatic load_box(box_type b);
      start <= 1'b0;
      wait (pending == 0);
      repeat (RSP_LAT + 4) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_SPARE_LO;
      csr_wdata <= $urandom;
      @(posedge clock);
      csr_index <= CSR_X_LOW;
      csr_wdata <= b.x_low;
      @(posedge clock);
      csr_index <= CSR_X_HIGH;
      csr_wdata <= b.x_high;
      @(posedge clock);
      csr_index <= CSR_Y_LOW;
      csr_wdata <= b.y_low;
      @(posedge clock);
      csr_index <= CSR_Y_HIGH;
      csr_wdata <= b.y_high;
      @(posedge clock);
      csr_index <= CSR_Z_LOW;
      csr_wdata <= b.z_low;
      @(posedge clock);
      csr_index <= CSR_Z_HIGH;
      csr_wdata <= b.z_high;
      @(posedge clock);
      csr_index <= CSR_SPARE_HI;
      csr_wdata <= $urandom;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      cur_box = b;
   endtask

   initial begin
      box_type settings[5];
      longint zh, xh;
      int burst;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      quiet_cycles = 0;
      cur_box = '{RST_X_LOW, RST_X_HIGH, RST_Y_LOW, RST_Y_HIGH, RST_Z_LOW, RST_Z_HIGH};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed items on the default box
      zh = RST_Z_HIGH;
      xh = RST_X_HIGH;
      ray(0, 0, 2 * zh, 0, 0, -UNIT);           // straight down: top face, a lone hit
      ray(1000, -2000, -3 * zh, 0, 0, UNIT);    // from below, line still meets the top
      ray(0, 0, 0, UNIT, 0, 0);                 // level along x: both x faces, equal z
      ray(0, 0, 0, 0, -UNIT, 0);                // level along y
      ray(0, 0, 0, 0, 0, 0);                    // all components zero
      ray(xh, 0, 0, 0, 0, UNIT);                // on the x high face: strict bounds miss the top, the x high face hits
      ray(0, 0, zh, UNIT, 0, 0);                // in the top plane: top face hit
      ray(0, 0, 1000, UNIT / 2, 0, UNIT / 3);   // slanted: side and top compete
      ray(0, 100, -1000, UNIT / 3, UNIT / 5, -UNIT / 7);
      ray(3 * xh, 0, 0, -UNIT, 0, 1);           // tiny z step
      ray(2147483647, 2147483647, 2147483647, UNIT, UNIT, UNIT);
      ray(-2147483648, -2147483648, -2147483648, -UNIT, -UNIT, -UNIT);
      ray(-2147483648, 2147483647, 0, 1, -1, -UNIT);
      ray(0, 0, -2147483648, 0, 0, UNIT);
      ray(2147483647, 0, 0, -UNIT, 0, 0);       // far away, saturating cuts
      ray(0, 2 * RST_Y_HIGH, 0, 0, -UNIT, 3);
      ray(1, 1, 1, -1, -1, -1);

      settings[0] = '{-32'sd5120000, 32'sd5120000, -32'sd15488000, 32'sd15488000,
                      -32'sd5120000, 32'sd5120000};
      settings[1] = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                      32'sh8000_0000, 32'sh7fff_ffff};
      settings[2] = '{-32'sd700, 32'sd900, -32'sd1200, 32'sd400, -32'sd300, 32'sd1500};
      settings[3] = '{32'sd5000, -32'sd5000, -32'sd20000, 32'sd20000,
                      32'sd8000, -32'sd8000};      // bounds in the wrong order
      settings[4] = '{32'sh7fff_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_ff00,
                      -32'sd1000000, 32'sd2000000};

      foreach (settings[p]) begin
         load_box(settings[p]);
         burst = 0;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // occasional back-to-back stretches
            if (burst == 0 && $urandom_range(29) == 0) burst = $urandom_range(60, 20);
            if (burst > 0) begin
               burst--;
               send_ray(rand_ray(), 0);
            end else begin
               send_ray(rand_ray(), rand_gap());
            end
         end
      end
      start <= 1'b0;

      wait (pending == 0);
      repeat (RSP_LAT + 10) @(posedge clock);
      if (fails == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> files.f
sv/rbe_pkg.sv
sv/rbe_cut.sv
sv/rbe_select.sv
sv/ray_box_entry_point.sv
tb/sv/ray_box_entry_point_checker.sv
tb/sv/ray_box_entry_point_tb.sv
